// ----- hw/rtl/differential_drive_mixer_defines.svh -----
// Assertion macros used by the checker file of the differential drive mixer.
`ifndef DIFFERENTIAL_DRIVE_MIXER_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_MIXER_DEFINES_SVH

// Check a clocked property, held off while reset is asserted.
`define DDM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define DDM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/ddm_pkg.sv -----
// Shared types and constants for the differential drive mixer.
package ddm_pkg;

  localparam int unsigned AdcBits  = 10;
  localparam int unsigned DutyW    = 16;
  localparam int unsigned FieldW   = 16;
  localparam int unsigned ProdW    = AdcBits + DutyW;
  localparam int unsigned MidSh    = AdcBits - 1;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [AdcBits-1:0] MidCode = {1'b1, {MidSh{1'b0}}};
  // Divisor of the base duty; a deviation at or above it saturates to full scale.
  localparam logic [AdcBits-1:0] SatDev  = MidCode - AdcBits'(1);

  localparam logic [DutyW-1:0] PwmTopRst   = 16'd10000;
  localparam logic [7:0]       OvertempRst = 8'd70;

  localparam logic [CfgIdxW-1:0] RegPwmTop   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegOvertemp = 2'd1;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } drive_dir_e;

  typedef enum logic {
    ACT_BRAKE  = 1'b0,
    ACT_SAMPLE = 1'b1
  } action_e;

  // Per-sample control that rides along the arithmetic pipeline.
  typedef struct packed {
    drive_dir_e dir;
    logic       kill;
    logic       light;
    logic       sneg;
    logic       sat;
  } ddm_ctl_t;

endpackage

// ----- hw/rtl/differential_drive_mixer.sv -----
// Differential drive mixer: brake latch, over-temperature cutoff and duty mixing pipeline.
// Throughput: one transaction per cycle unless the result channel stalls;
// a four-stage pipeline plus output register.
// Brake events update state at acceptance and never reach the output.
// Reset: rst_ni is asynchronous active low; it empties the pipeline, clears the
// brake state and loads pwm_top = 10000 and overtemp_limit = 70.
module differential_drive_mixer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [9:0]  speed_sample_i,
  input  logic [9:0]  steer_sample_i,
  input  logic [10:0] temperature_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] left_duty_o,
  output logic [15:0] right_duty_o,
  output logic [1:0]  drive_dir_o,
  output logic        brake_light_o
);

  localparam int unsigned AdcBits = ddm_pkg::AdcBits;
  localparam int unsigned DutyW   = ddm_pkg::DutyW;
  localparam int unsigned ProdW   = ddm_pkg::ProdW;
  localparam int unsigned MidSh   = ddm_pkg::MidSh;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes must arrive only while the block is idle,
  // which the block itself does not enforce, so every stage reads them directly.
  // ---------------------------------------------------------------------------
  logic [DutyW-1:0] pwm_top_q;
  logic [7:0]       overtemp_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_top_q  <= ddm_pkg::PwmTopRst;
      overtemp_q <= ddm_pkg::OvertempRst;
    end else if (cfg_valid_i) begin
      // Drop writes to indexes beyond the register list.
      if (cfg_index_i == ddm_pkg::RegPwmTop) pwm_top_q <= cfg_data_i;
      if (cfg_index_i == ddm_pkg::RegOvertemp) overtemp_q <= cfg_data_i[7:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control. Each stage advances when it is empty or when the
  // stage after it advances, so bubbles collapse and a waiting result does not
  // block new transactions from entering while any stage is still empty.
  // ---------------------------------------------------------------------------
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, out_v_q;
  logic out_en, s4_en, s3_en, s2_en, s1_en;
  logic in_acc, smp_acc;

  assign out_en  = !out_v_q || out_ready_i;
  assign s4_en   = !s4_v_q || out_en;
  assign s3_en   = !s3_v_q || s4_en;
  assign s2_en   = !s2_v_q || s3_en;
  assign s1_en   = !s1_v_q || s2_en;

  assign in_ready_o = s1_en;
  assign in_acc     = in_valid_i && s1_en;
  assign smp_acc    = in_acc && (action_i == ddm_pkg::ACT_SAMPLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_en)  s1_v_q  <= smp_acc;
      if (s2_en)  s2_v_q  <= s1_v_q;
      if (s3_en)  s3_v_q  <= s2_v_q;
      if (s4_en)  s4_v_q  <= s3_v_q;
      if (out_en) out_v_q <= s4_v_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Acceptance: decode the sample and run the brake state machine in order of
  // arrival. Brake state updates here, so the lamp value travels with the item.
  // ---------------------------------------------------------------------------
  logic [ddm_pkg::FieldW-1:0] speed_ext, steer_ext;
  logic [AdcBits-1:0]         speed, steer, dev, smag;
  logic                       sneg, overtemp;
  ddm_pkg::drive_dir_e        dir;
  ddm_pkg::ddm_ctl_t          ctl0;

  logic pending_q, pending_d;
  logic latch_q, latch_d;
  logic light_q, light_d;

  always_comb begin
    // Mask the converter readings to the converter width.
    speed_ext = ddm_pkg::FieldW'(speed_sample_i);
    steer_ext = ddm_pkg::FieldW'(steer_sample_i);
    speed     = speed_ext[AdcBits-1:0];
    steer     = steer_ext[AdcBits-1:0];

    if (speed > ddm_pkg::MidCode)      dir = ddm_pkg::DIR_FWD;
    else if (speed < ddm_pkg::MidCode) dir = ddm_pkg::DIR_REV;
    else                               dir = ddm_pkg::DIR_STOP;

    dev  = (speed >= ddm_pkg::MidCode) ? speed - ddm_pkg::MidCode
                                       : ddm_pkg::MidCode - speed;
    sneg = steer < ddm_pkg::MidCode;
    smag = sneg ? ddm_pkg::MidCode - steer : steer - ddm_pkg::MidCode;

    // Negative temperatures are sensor error codes; they exceed only a negative limit.
    overtemp = $signed(temperature_i) > $signed({{3{overtemp_q[7]}}, overtemp_q});
  end

  always_comb begin
    pending_d = pending_q;
    latch_d   = latch_q;
    light_d   = light_q;
    if (in_acc) begin
      if (action_i == ddm_pkg::ACT_BRAKE) begin
        pending_d = 1'b1;
        latch_d   = !latch_q;
      end else if (dir != ddm_pkg::DIR_STOP && pending_q) begin
        // Light the lamp; release brake and lamp at once if the latch is clear.
        pending_d = latch_q;
        light_d   = latch_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      latch_q   <= 1'b0;
      light_q   <= 1'b0;
    end else begin
      pending_q <= pending_d;
      latch_q   <= latch_d;
      light_q   <= light_d;
    end
  end

  always_comb begin
    ctl0.dir   = dir;
    // Centered stick, pending brake and over-temperature all stop the motors.
    ctl0.kill  = (dir == ddm_pkg::DIR_STOP) || pending_q || overtemp;
    ctl0.light = light_d;
    ctl0.sneg  = sneg;
    ctl0.sat   = dev >= ddm_pkg::SatDev;
  end

  // Stage 1: input register.
  ddm_pkg::ddm_ctl_t  s1_ctl_q;
  logic [AdcBits-1:0] s1_dev_q, s1_smag_q;

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_ctl_q  <= ctl0;
      s1_dev_q  <= dev;
      s1_smag_q <= smag;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 -> 2: scale both deviations by the full-scale count.
  // ---------------------------------------------------------------------------
  logic [ProdW-1:0]  prod_b, prod_s;
  ddm_pkg::ddm_ctl_t s2_ctl_q;
  logic [ProdW-1:0]  s2_prod_b_q, s2_prod_s_q;

  assign prod_b = ProdW'(s1_dev_q) * ProdW'(pwm_top_q);
  assign prod_s = ProdW'(s1_smag_q) * ProdW'(pwm_top_q);

  always_ff @(posedge clk_i) begin
    if (s2_en) begin
      s2_ctl_q    <= s1_ctl_q;
      s2_prod_b_q <= prod_b;
      s2_prod_s_q <= prod_s;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2 -> 3: estimate the quotient by (mid - 1) with the geometric series
  // x/(2^k - 1) ~ (x + x>>k + x>>2k + x>>3k) >> k. The estimate is low by at
  // most one. The steering offset divides by mid, a plain shift.
  // ---------------------------------------------------------------------------
  logic [ProdW:0]    est_sum;
  logic [DutyW-1:0]  q_est, off_mag;
  ddm_pkg::ddm_ctl_t s3_ctl_q;
  logic [ProdW-1:0]  s3_x_q;
  logic [DutyW-1:0]  s3_q_q, s3_m_q;

  always_comb begin
    est_sum = (ProdW+1)'(s2_prod_b_q)
            + (ProdW+1)'(s2_prod_b_q >> MidSh)
            + (ProdW+1)'(s2_prod_b_q >> (2 * MidSh))
            + (ProdW+1)'(s2_prod_b_q >> (3 * MidSh));
    q_est   = DutyW'(est_sum >> MidSh);
    off_mag = DutyW'(s2_prod_s_q >> MidSh);
  end

  always_ff @(posedge clk_i) begin
    if (s3_en) begin
      s3_ctl_q <= s2_ctl_q;
      s3_x_q   <= s2_prod_b_q;
      s3_q_q   <= q_est;
      s3_m_q   <= off_mag;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3 -> 4: correct the quotient from its remainder; a saturated stick
  // takes full scale.
  // ---------------------------------------------------------------------------
  logic [ProdW-1:0]  q_times, rem;
  logic [DutyW-1:0]  base;
  ddm_pkg::ddm_ctl_t s4_ctl_q;
  logic [DutyW-1:0]  s4_base_q, s4_m_q;

  always_comb begin
    q_times = (ProdW'(s3_q_q) << MidSh) - ProdW'(s3_q_q);
    rem     = s3_x_q - q_times;
    if (s3_ctl_q.sat) base = pwm_top_q;
    else if (rem >= ProdW'(ddm_pkg::SatDev)) base = s3_q_q + DutyW'(1);
    else base = s3_q_q;
  end

  always_ff @(posedge clk_i) begin
    if (s4_en) begin
      s4_ctl_q  <= s3_ctl_q;
      s4_base_q <= base;
      s4_m_q    <= s3_m_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4 -> output: mix base and offset into the two sides, clamp to
  // 0..pwm_top, and apply the stop conditions.
  // ---------------------------------------------------------------------------
  logic [DutyW:0]      sum;
  logic [DutyW-1:0]    hi, lo, left, right;
  ddm_pkg::drive_dir_e dir_out;

  always_comb begin
    sum = (DutyW+1)'(s4_base_q) + (DutyW+1)'(s4_m_q);
    hi  = (sum > (DutyW+1)'(pwm_top_q)) ? pwm_top_q : sum[DutyW-1:0];
    lo  = (s4_base_q >= s4_m_q) ? s4_base_q - s4_m_q : '0;
    // Steering right of center adds to the right side.
    left    = s4_ctl_q.sneg ? hi : lo;
    right   = s4_ctl_q.sneg ? lo : hi;
    dir_out = s4_ctl_q.dir;
    if (s4_ctl_q.kill) begin
      left    = '0;
      right   = '0;
      dir_out = ddm_pkg::DIR_STOP;
    end
  end

  logic [DutyW-1:0]    out_left_q, out_right_q;
  ddm_pkg::drive_dir_e out_dir_q;
  logic                out_light_q;

  // Hold the result until it is taken.
  always_ff @(posedge clk_i) begin
    if (out_en) begin
      out_left_q  <= left;
      out_right_q <= right;
      out_dir_q   <= dir_out;
      out_light_q <= s4_ctl_q.light;
    end
  end

  assign out_valid_o   = out_v_q;
  assign left_duty_o   = out_left_q;
  assign right_duty_o  = out_right_q;
  assign drive_dir_o   = out_dir_q;
  assign brake_light_o = out_light_q;

endmodule

// ----- hw/rtl/ddm_checker.sv -----
// Port-level assertion checker for the differential drive mixer, with its bind.
`include "differential_drive_mixer_defines.svh"

module ddm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] left_duty_o,
  input logic [15:0] right_duty_o,
  input logic [1:0]  drive_dir_o,
  input logic        brake_light_o
);

  // Hold a stalled result transaction.
  `DDM_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(left_duty_o) && $stable(right_duty_o) && $stable(drive_dir_o) && $stable(brake_light_o), "stalled result changed")

  // A stopped bridge drives no duty on either side.
  `DDM_ASSERT_IMP(a_stop_zero, out_valid_o && drive_dir_o == ddm_pkg::DIR_STOP, left_duty_o == 16'd0 && right_duty_o == 16'd0, "duty while stopped")

  // A lit brake lamp means the brake is still pending, so the motors stop.
  `DDM_ASSERT_IMP(a_light_stop, out_valid_o && brake_light_o, drive_dir_o == ddm_pkg::DIR_STOP, "motors driven with brake lamp lit")

endmodule

bind differential_drive_mixer ddm_checker u_ddm_checker (.*);

// ----- tb/differential_drive_mixer_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the differential drive mixer: random and directed traffic.
module differential_drive_mixer_tb;

  // Idle cycles to let the block settle before a register write or the final verdict.
  localparam int SettleCycles = 8;
  // Longest run of cycles with no transaction on any channel before giving up.
  localparam int StallLimit   = 2000;
  localparam int MaxReports   = 10;
  localparam int PhaseItems   = 125;
  localparam int NumPhases    = 6;

  // One input transaction as seen by the block.
  typedef struct {
    ddm_pkg::action_e   act;
    logic [9:0]         speed;
    logic [9:0]         steer;
    logic signed [10:0] temp;
  } drive_cmd_t;

  // One motor command as produced by the block.
  typedef struct {
    logic [15:0]         left;
    logic [15:0]         right;
    ddm_pkg::drive_dir_e dir;
    logic                light;
  } motor_cmd_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_valid_i    = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i    = '0;
  logic [15:0] cfg_data_i     = '0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic        action_i       = 1'b0;
  logic [9:0]  speed_sample_i = '0;
  logic [9:0]  steer_sample_i = '0;
  logic [10:0] temperature_i  = '0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [15:0] left_duty_o;
  logic [15:0] right_duty_o;
  logic [1:0]  drive_dir_o;
  logic        brake_light_o;

  differential_drive_mixer DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .speed_sample_i (speed_sample_i),
    .steer_sample_i (steer_sample_i),
    .temperature_i  (temperature_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .left_duty_o    (left_duty_o),
    .right_duty_o   (right_duty_o),
    .drive_dir_o    (drive_dir_o),
    .brake_light_o  (brake_light_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the registers and the brake state.
  logic [15:0]        duty_top    = ddm_pkg::PwmTopRst;
  logic signed [7:0]  heat_limit  = ddm_pkg::OvertempRst;
  logic               brake_armed = 1'b0;
  logic               brake_hold  = 1'b0;
  logic               lamp_lit    = 1'b0;

  drive_cmd_t cmd_backlog[$];
  motor_cmd_t motor_expected[$];
  drive_cmd_t cur_cmd;
  logic       in_busy;
  logic       calm = 1'b0;
  int         send_gap = 0;
  int         take_gap = 0;
  int         fault_count = 0;
  int         quiet_cycles = 0;

  function automatic longint clamp_duty(longint v, longint top);
    if (v < 0) return 0;
    if (v > top) return top;
    return v;
  endfunction

  // Apply one accepted transaction to the shadow state; queue the motor command it yields.
  function void predict_motor(drive_cmd_t c);
    longint     dev, base, off, top, mid;
    motor_cmd_t m;
    if (c.act == ddm_pkg::ACT_BRAKE) begin
      // A button press arms the brake and flips the hold latch; nothing comes out.
      brake_armed = 1'b1;
      brake_hold  = ~brake_hold;
      return;
    end
    top = longint'(duty_top);
    mid = longint'(ddm_pkg::MidCode);
    dev = longint'(c.speed) - mid;
    if (dev > 0) m.dir = ddm_pkg::DIR_FWD;
    else if (dev < 0) m.dir = ddm_pkg::DIR_REV;
    else m.dir = ddm_pkg::DIR_STOP;
    if (dev < 0) dev = -dev;
    base = clamp_duty(dev * top / longint'(ddm_pkg::SatDev), top);
    // Signed division truncates toward zero, as the steering offset requires.
    off = (longint'(c.steer) - mid) * top / mid;
    m.left  = 16'(clamp_duty(base - off, top));
    m.right = 16'(clamp_duty(base + off, top));
    if (m.dir == ddm_pkg::DIR_STOP) begin
      // Centered stick: stop, leave the brake state alone.
      m.left  = '0;
      m.right = '0;
    end else if (brake_armed) begin
      m.left   = '0;
      m.right  = '0;
      m.dir    = ddm_pkg::DIR_STOP;
      lamp_lit = 1'b1;
      // Latch clear: release the brake within the same sample.
      if (!brake_hold) begin
        brake_armed = 1'b0;
        lamp_lit    = 1'b0;
      end
    end else if (longint'(c.temp) > longint'(heat_limit)) begin
      m.left  = '0;
      m.right = '0;
      m.dir   = ddm_pkg::DIR_STOP;
    end
    m.light = lamp_lit;
    motor_expected.push_back(m);
  endfunction

  function void report_fault(string what);
    if (fault_count < MaxReports) $display("%0t: %s", $time, what);
    fault_count++;
  endfunction

  // Mostly short gaps, a few long ones; none at all in calm phases.
  function automatic int draw_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Converter reading with extra weight on the rails and around the midpoint.
  function automatic logic [9:0] pick_adc();
    case ($urandom_range(0, 9))
      0: return 10'd0;
      1: return 10'h3FF;
      2: return ddm_pkg::MidCode + 10'($urandom_range(0, 2)) - 10'd1;
      default: return 10'($urandom);
    endcase
  endfunction

  function automatic drive_cmd_t random_cmd();
    drive_cmd_t c;
    c.act   = ($urandom_range(0, 99) < 8) ? ddm_pkg::ACT_BRAKE : ddm_pkg::ACT_SAMPLE;
    c.speed = pick_adc();
    c.steer = pick_adc();
    // Half the readings sit just at or below the limit so the motors mostly run.
    if ($urandom_range(0, 1))
      c.temp = 11'($urandom_range(0, 1128) - 1000);
    else
      c.temp = 11'(int'(heat_limit) - int'($urandom_range(0, 60)));
    return c;
  endfunction

  function void queue_sample(int speed, int steer, int temp);
    drive_cmd_t c;
    c.act   = ddm_pkg::ACT_SAMPLE;
    c.speed = 10'(speed);
    c.steer = 10'(steer);
    c.temp  = 11'(temp);
    cmd_backlog.push_back(c);
  endfunction

  function void queue_brake();
    drive_cmd_t c;
    c = random_cmd();
    c.act = ddm_pkg::ACT_BRAKE;
    cmd_backlog.push_back(c);
  endfunction

  // Hold until nothing is queued, in flight or expected, then let the pipeline settle.
  task automatic drain();
    while (cmd_backlog.size() != 0 || in_valid_i || motor_expected.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [ddm_pkg::CfgIdxW-1:0] idx, logic [15:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == ddm_pkg::RegPwmTop) duty_top = data;
    else heat_limit = data[7:0];
  endtask

  // Driver: present the next queued transaction, hold it until accepted, then idle
  // for a random gap.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_motor(cur_cmd);
        in_busy = 1'b0;
      end else begin
        in_busy = in_valid_i;
      end
      if (!in_busy) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          cur_cmd = cmd_backlog.pop_front();
          in_valid_i     <= 1'b1;
          action_i       <= cur_cmd.act;
          speed_sample_i <= cur_cmd.speed;
          steer_sample_i <= cur_cmd.steer;
          temperature_i  <= cur_cmd.temp;
          send_gap = draw_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest expectation and stall
  // the result channel at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      take_gap = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (motor_expected.size() == 0) begin
          report_fault($sformatf("unexpected result L=%0d R=%0d dir=%0d lamp=%0b",
                                 left_duty_o, right_duty_o, drive_dir_o, brake_light_o));
        end else begin
          motor_cmd_t want;
          want = motor_expected.pop_front();
          if (left_duty_o !== want.left || right_duty_o !== want.right ||
              drive_dir_o !== want.dir || brake_light_o !== want.light)
            report_fault($sformatf(
              "mismatch: exp L=%0d R=%0d dir=%0d lamp=%0b, got L=%0d R=%0d dir=%0d lamp=%0b",
              want.left, want.right, want.dir, want.light,
              left_duty_o, right_duty_o, drive_dir_o, brake_light_o));
        end
      end
      if (take_gap > 0) begin
        take_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        take_gap = draw_gap();
      end
    end
  end

  // Watchdog: end the run when no channel has moved a transaction for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("differential_drive_mixer_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [15:0]       top_val;
    logic signed [7:0] lim_val;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed traffic at reset values (full scale 10000, limit 70).
    queue_sample(1023, 512, 25);    // full forward, saturated base
    queue_sample(0, 512, 25);       // full reverse
    queue_sample(512, 0, 25);       // centered stick
    queue_sample(513, 1023, 25);    // just off center, hard steer one way
    queue_sample(511, 0, 25);       // just off center, hard steer the other way
    queue_sample(700, 300, 70);     // at the temperature limit: still runs
    queue_sample(700, 300, 71);     // one above the limit: stop
    queue_sample(700, 300, 128);    // far above the limit: stop
    queue_sample(300, 900, -1000);  // negative error code
    queue_sample(300, 900, -1);
    queue_brake();                  // arm, latch set
    queue_sample(512, 700, 25);     // centered stick leaves the brake pending
    queue_sample(800, 600, 25);     // brake holds, lamp on
    queue_sample(200, 400, 25);     // still held
    queue_brake();                  // latch clear
    queue_sample(800, 600, 25);     // released in the same sample, lamp off
    queue_sample(800, 600, 25);     // runs again
    queue_brake();
    queue_brake();                  // two presses: pending with latch clear
    queue_sample(900, 100, 25);
    queue_sample(1023, 1023, -1000);
    queue_sample(0, 0, 128);
    drain();

    // Random phases, each under its own register setting.
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin top_val = 16'hFFFF; lim_val = 8'sd127;  end
        1: begin top_val = 16'd1;    lim_val = -8'sd128; end
        2: begin top_val = 16'd0;    lim_val = 8'sd0;    end  // zero full scale
        5: begin top_val = ddm_pkg::PwmTopRst; lim_val = ddm_pkg::OvertempRst; end
        default: begin
          top_val = 16'($urandom_range(1, 65535));
          lim_val = 8'($urandom_range(0, 255));
        end
      endcase
      write_reg(ddm_pkg::RegPwmTop, top_val);
      write_reg(ddm_pkg::RegOvertemp, {{8{lim_val[7]}}, lim_val});
      @(negedge clk_i);
      calm = (p == 3);
      for (int i = 0; i < PhaseItems; i++) cmd_backlog.push_back(random_cmd());
      drain();
    end

    if (fault_count == 0 && motor_expected.size() == 0) begin
      $display("differential_drive_mixer_tb OK");
    end else begin
      $display("differential_drive_mixer_tb NOT OK");
    end
    $finish;
  end

endmodule
